// ===== design/rtpg_pkg.sv =====
// ---------------------------------------------------------------------------
// rtpg_pkg
// Shared constants and types of the raster test pattern generator.
// ---------------------------------------------------------------------------
package rtpg_pkg;

	// Coordinate width and largest usable frame size
	localparam int COORD_BITS = 13;
	localparam logic [15:0] COORD_MAX = 16'((1 << COORD_BITS) - 2);

	// Configuration register widths and reset values
	localparam int SIZE_BITS  = 13;
	localparam int BLOCK_BITS = 16;
	localparam int PIB_BITS   = 14;
	localparam logic [SIZE_BITS-1:0]  WIDTH_RST  = 13'd512;
	localparam logic [SIZE_BITS-1:0]  HEIGHT_RST = 13'd512;
	localparam logic [BLOCK_BITS-1:0] BLOCK_RST  = 16'd4096;

	// Register indexes
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK_WORDS  = 2'd2;

	// Word tags and flags
	localparam logic [15:0] TAG_X       = 16'h8000;
	localparam logic [15:0] TAG_Y       = 16'h4000;
	localparam logic [15:0] FLAG_LINE   = 16'h1000;
	localparam logic [15:0] FLAG_FRAME  = 16'h3000;
	localparam logic [15:0] OFFSET_STEP = 16'd8;
	localparam logic [15:0] OFFSET_MAX  = 16'hFFF0;

	// One generated pixel, handed to the word serializer
	typedef struct packed {
		logic                  hdr;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [15:0]           z;
	} pix_t;

endpackage

// ===== design/rtpg_if.sv =====
// ---------------------------------------------------------------------------
// rtpg_if
// Handshake channels of the raster test pattern generator.
// ---------------------------------------------------------------------------

// Tick channel: one item with advance set requests the next pixel
interface rtpg_in_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink   (input valid, input advance, output ready);
endinterface

// Stream channel: one item is one output word
interface rtpg_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] word;
	logic        is_header;
	logic        last;

	modport source (output valid, output word, output is_header, output last, input ready);
	modport sink   (input valid, input word, input is_header, input last, output ready);
endinterface

// ===== design/rtpg_pixel.sv =====
// ---------------------------------------------------------------------------
// rtpg_pixel
// Scan position, frame offset and block counter; produces one pixel per tick with advance set.
// ---------------------------------------------------------------------------
module rtpg_pixel
	import rtpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rtpg_in_if.sink               tick,
	input  logic [SIZE_BITS-1:0]  frame_width,
	input  logic [SIZE_BITS-1:0]  frame_height,
	input  logic [BLOCK_BITS-1:0] block_words,
	output logic                  pix_valid,
	input  logic                  pix_ready,
	output pix_t                  pix
);

	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic [15:0]           offset_q;
	logic [PIB_BITS-1:0]   pib_q;
	logic                  valid_s1;
	pix_t                  pix_s1;

	logic [COORD_BITS-1:0] w, h, x_a, y_a, x_n, y_n, pos_x_n, pos_y_n;
	logic [15:0]           off_inc, off_n, z_n;
	logic [PIB_BITS-1:0]   per_block, pib_n;
	logic [PIB_BITS:0]     pib_inc;
	logic                  x_wrap, f_wrap, go;

	// Clamp frame sizes to 1..COORD_MAX
	always_comb begin
		if (frame_width == '0) begin
			w = COORD_BITS'(1);
		end else if (16'(frame_width) > COORD_MAX) begin
			w = COORD_MAX[COORD_BITS-1:0];
		end else begin
			w = COORD_BITS'(frame_width);
		end
		if (frame_height == '0) begin
			h = COORD_BITS'(1);
		end else if (16'(frame_height) > COORD_MAX) begin
			h = COORD_MAX[COORD_BITS-1:0];
		end else begin
			h = COORD_BITS'(frame_height);
		end
	end

	// Position step with line and frame wrap; frame offset step on frame wrap
	always_comb begin
		x_wrap  = pos_x_q > w;
		x_a     = x_wrap ? COORD_BITS'(1) : pos_x_q;
		y_a     = x_wrap ? pos_y_q + COORD_BITS'(1) : pos_y_q;
		f_wrap  = y_a > h;
		x_n     = f_wrap ? COORD_BITS'(1) : x_a;
		y_n     = f_wrap ? COORD_BITS'(1) : y_a;
		pos_x_n = (x_wrap || f_wrap) ? COORD_BITS'(2) : pos_x_q + COORD_BITS'(1);
		pos_y_n = y_n;
		off_inc = offset_q + OFFSET_STEP;
		if (!f_wrap) begin
			off_n = offset_q;
		end else if (off_inc > OFFSET_MAX) begin
			off_n = '0;
		end else begin
			off_n = off_inc;
		end
	end

	// Value word
	always_comb begin
		z_n = {4'd0, x_n[7:0] + off_n[7:0], 4'd0};
		if (x_n == COORD_BITS'(1)) begin
			z_n = z_n | FLAG_LINE;
		end
		if (x_n == COORD_BITS'(1) && y_n == COORD_BITS'(1)) begin
			z_n = z_n | FLAG_FRAME;
		end
	end

	// Block counter
	always_comb begin
		per_block = block_words[BLOCK_BITS-1:2];
		if (per_block == '0) begin
			per_block = PIB_BITS'(1);
		end
		pib_inc = {1'b0, pib_q} + (PIB_BITS+1)'(1);
		pib_n   = (pib_inc >= {1'b0, per_block}) ? '0 : pib_inc[PIB_BITS-1:0];
	end

	assign tick.ready = !valid_s1;
	assign go         = tick.valid && tick.ready && tick.advance;

	// State and pixel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= COORD_BITS'(1);
			pos_y_q  <= COORD_BITS'(1);
			offset_q <= '0;
			pib_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (go) begin
				pos_x_q  <= pos_x_n;
				pos_y_q  <= pos_y_n;
				offset_q <= off_n;
				pib_q    <= pib_n;
				valid_s1 <= 1'b1;
			end else if (pix_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pix_s1.hdr <= (pib_q == '0);
			pix_s1.x   <= x_n;
			pix_s1.y   <= y_n;
			pix_s1.z   <= z_n;
		end
	end

	assign pix_valid = valid_s1;
	assign pix       = pix_s1;

endmodule

// ===== design/rtpg_serial.sv =====
// ---------------------------------------------------------------------------
// rtpg_serial
// Splits one pixel into an optional block header, x, y and two value words, one per cycle while the stream is ready.
// ---------------------------------------------------------------------------
module rtpg_serial
	import rtpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_t                  pix,
	input  logic [BLOCK_BITS-1:0] block_words,
	rtpg_out_if.source            stream
);

	localparam logic [2:0] WORD_HDR = 3'd0;
	localparam logic [2:0] WORD_X   = 3'd1;
	localparam logic [2:0] WORD_Y   = 3'd2;
	localparam logic [2:0] WORD_Z0  = 3'd3;
	localparam logic [2:0] WORD_Z1  = 3'd4;

	logic       busy_q;
	logic [2:0] idx_q;
	pix_t       pix_q;
	logic       done;

	assign done      = stream.valid && stream.ready && (idx_q == WORD_Z1);
	assign pix_ready = !busy_q || done;

	// Word index and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= WORD_HDR;
		end else begin
			if (pix_ready) begin
				busy_q <= pix_valid;
				idx_q  <= pix.hdr ? WORD_HDR : WORD_X;
			end else if (stream.ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pix_q <= pix;
		end
	end

	// Output word select
	always_comb begin
		stream.is_header = 1'b0;
		stream.last      = 1'b0;
		unique case (idx_q)
			WORD_HDR: begin
				stream.word      = block_words;
				stream.is_header = 1'b1;
			end
			WORD_X:  stream.word = TAG_X | 16'(pix_q.x);
			WORD_Y:  stream.word = TAG_Y | 16'(pix_q.y);
			WORD_Z0: stream.word = pix_q.z;
			WORD_Z1: begin
				stream.word = pix_q.z;
				stream.last = 1'b1;
			end
			default: stream.word = pix_q.z;
		endcase
	end

	assign stream.valid = busy_q;

endmodule

// ===== design/raster_test_pattern_generator_top.sv =====
// ---------------------------------------------------------------------------
// raster_test_pattern_generator_top
// Synthetic raster source: four words per pixel plus a header word per block.
// ---------------------------------------------------------------------------
// Path: an accepted tick with advance set is registered in the pixel register,
//   then in the serializer register, which shows the first word of its pixel.
// Throughput: one output word per cycle while the stream is ready; the word
//   serializer sets this. Idle ticks give no words; ticks overlap pixel output.
// Reset: position 1,1, frame offset 0, block counter 0, registers at defaults.
module raster_test_pattern_generator_top
	import rtpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rtpg_in_if.sink               tick,
	rtpg_out_if.source            stream,
	input  logic                  write_en,
	input  logic [1:0]            reg_index,
	input  logic [BLOCK_BITS-1:0] write_data
);

	logic [SIZE_BITS-1:0]  frame_width_q;
	logic [SIZE_BITS-1:0]  frame_height_q;
	logic [BLOCK_BITS-1:0] block_words_q;
	logic                  pix_valid, pix_ready;
	pix_t                  pix;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			block_words_q  <= BLOCK_RST;
		end else if (write_en) begin
			unique case (reg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= write_data[SIZE_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= write_data[SIZE_BITS-1:0];
				REG_BLOCK_WORDS:  block_words_q  <= write_data;
				default: ;
			endcase
		end
	end

	rtpg_pixel u_pixel (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.block_words  (block_words_q),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pix          (pix)
	);

	rtpg_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.block_words (block_words_q),
		.stream      (stream)
	);

endmodule

// ===== design/rtpg_check.sv =====
// ---------------------------------------------------------------------------
// rtpg_check
// Port-level checks of the raster test pattern generator.
// ---------------------------------------------------------------------------
module rtpg_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_word,
	input logic        out_is_header,
	input logic        out_last
);

	// A header word never closes a pixel
	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_header |-> !out_last)
		else $error("header word marked last");

	// The closing word is a value word: no x or y tag
	a_last_is_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_word[15:14] == 2'b00)
		else $error("last word carries a coordinate tag");

	// Once an x word is taken, the y word follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_is_header && out_word[15] |=> out_valid)
		else $error("gap inside a pixel");

	// A stalled word is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("stalled word changed");

endmodule

bind raster_test_pattern_generator_top rtpg_check u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (stream.valid),
	.out_ready     (stream.ready),
	.out_word      (stream.word),
	.out_is_header (stream.is_header),
	.out_last      (stream.last)
);

// ===== sim/raster_test_pattern_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// raster_test_pattern_generator_top_tb
// Self-checking bench for the raster test pattern generator. Pixel ticks go in
// over the tick channel in random bursts. A scoreboard model predicts the
// header, x, y and value words of every pixel, and each word taken from the
// stream channel is checked against the oldest prediction. The run covers
// directed corner cases, random frame and block settings under receiver
// stalls, and a run of one-pixel frames that steps the frame offset on
// every tick.
// ---------------------------------------------------------------------------
module raster_test_pattern_generator_top_tb;
	import rtpg_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_PHASES  = 5;
	localparam int PHASE_TICKS  = 26;
	localparam int SWEEP_TICKS  = 20;
	localparam int MAX_PRINTS   = 30;

	// Receiver stall modes
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_HALF, RX_QUARTER} rx_mode_e;

	// One word of the output stream
	typedef struct packed {
		logic [15:0] word;
		logic        is_header;
		logic        last;
	} stream_word_t;

	// One step of the directed table: a register write or a tick, with
	// hand-written words where they are obvious
	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [15:0] val;
		logic        adv;
		bit          typed;
		bit          t_hdr;
		logic [15:0] t_head;
		logic [15:0] t_x;
		logic [15:0] t_y;
		logic [15:0] t_z;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic write_en;
	logic [1:0] reg_index;
	logic [BLOCK_BITS-1:0] write_data;

	rtpg_in_if  tick_if();
	rtpg_out_if stream_if();

	raster_test_pattern_generator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick_if),
		.stream     (stream_if),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	always #1 clk = ~clk;

	// Scoreboard model state and its copy of the registers
	logic [SIZE_BITS-1:0]  cfg_width  = WIDTH_RST;
	logic [SIZE_BITS-1:0]  cfg_height = HEIGHT_RST;
	logic [BLOCK_BITS-1:0] cfg_block  = BLOCK_RST;
	logic [COORD_BITS-1:0] gen_x       = COORD_BITS'(1);
	logic [COORD_BITS-1:0] gen_y       = COORD_BITS'(1);
	logic [15:0]           gen_offset  = '0;
	logic [PIB_BITS-1:0]   gen_blk_pix = '0;

	stream_word_t pix_words [5];
	int           pix_count;
	stream_word_t pending_words [$];

	int  fail_count, ticks_sent, pixels_sent, words_checked, headers_checked;
	int  settings_count, offset_wraps, cycle_count, burst_left;
	bit  hold_off = 1'b0;
	bit  rand_started = 1'b0;
	dir_row_t dir_rows [$];

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Words of the next pixel into pix_words, state stepped
	function automatic void raster_next_pixel();
		int w, h, per_blk, x, y, off, z, n;
		w = int'(cfg_width);
		if (w == 0) w = 1;
		else if (w > int'(COORD_MAX)) w = int'(COORD_MAX);
		h = int'(cfg_height);
		if (h == 0) h = 1;
		else if (h > int'(COORD_MAX)) h = int'(COORD_MAX);
		per_blk = int'(cfg_block >> 2);
		if (per_blk == 0) per_blk = 1;

		// line wrap, then frame wrap
		x = int'(gen_x);
		gen_x = COORD_BITS'(x + 1);
		if (x > w) begin
			x = 1;
			gen_x = COORD_BITS'(2);
			gen_y = gen_y + COORD_BITS'(1);
		end
		y = int'(gen_y);
		if (y > h) begin
			x = 1;
			y = 1;
			gen_x = COORD_BITS'(2);
			gen_y = COORD_BITS'(1);
			off = int'(gen_offset) + int'(OFFSET_STEP);
			if (off > int'(OFFSET_MAX)) begin
				off = 0;
				offset_wraps++;
			end
			gen_offset = 16'(off);
		end

		z = ((x + int'(gen_offset)) & 255) << 4;
		if (x == 1) z = z | int'(FLAG_LINE);
		if (x == 1 && y == 1) z = z | int'(FLAG_FRAME);

		n = 0;
		if (gen_blk_pix == '0) begin
			pix_words[0] = '{cfg_block, 1'b1, 1'b0};
			n = 1;
		end
		pix_words[n]   = '{16'(x) | TAG_X, 1'b0, 1'b0};
		pix_words[n+1] = '{16'(y) | TAG_Y, 1'b0, 1'b0};
		pix_words[n+2] = '{16'(z), 1'b0, 1'b0};
		pix_words[n+3] = '{16'(z), 1'b0, 1'b1};
		pix_count = n + 4;

		// shrunk blocks restart on the next pixel
		if (int'(gen_blk_pix) + 1 >= per_blk) gen_blk_pix = '0;
		else gen_blk_pix = gen_blk_pix + PIB_BITS'(1);
	endfunction

	function automatic dir_row_t tick_row(input logic adv);
		dir_row_t r;
		r = '{default: 0};
		r.adv = adv;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
		dir_row_t r;
		r = '{default: 0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic dir_row_t pixel_row(input bit hdr, input logic [15:0] head,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		dir_row_t r;
		r = tick_row(1'b1);
		r.typed = 1'b1;
		r.t_hdr = hdr;
		r.t_head = head;
		r.t_x = x;
		r.t_y = y;
		r.t_z = z;
		return r;
	endfunction

	// Hold the tick channel low until every predicted word is out
	task automatic wait_idle();
		tick_if.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		wait_idle();
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= val;
		case (idx)
			REG_FRAME_WIDTH:  cfg_width  = val[SIZE_BITS-1:0];
			REG_FRAME_HEIGHT: cfg_height = val[SIZE_BITS-1:0];
			REG_BLOCK_WORDS:  cfg_block  = val;
			default: ;
		endcase
		settings_count++;
		@(posedge clk);
		write_en <= 1'b0;
	endtask

	// Offer one tick, predict at accept, then keep the burst going or pause
	task automatic send_tick(input dir_row_t r);
		int gap;
		tick_if.valid   <= 1'b1;
		tick_if.advance <= r.adv;
		do @(negedge clk); while (tick_if.ready !== 1'b1);
		ticks_sent++;
		if (r.adv) begin
			pixels_sent++;
			raster_next_pixel();
			if (r.typed) begin
				pix_count = 0;
				if (r.t_hdr) begin
					pix_words[0] = '{r.t_head, 1'b1, 1'b0};
					pix_count = 1;
				end
				pix_words[pix_count]   = '{r.t_x, 1'b0, 1'b0};
				pix_words[pix_count+1] = '{r.t_y, 1'b0, 1'b0};
				pix_words[pix_count+2] = '{r.t_z, 1'b0, 1'b0};
				pix_words[pix_count+3] = '{r.t_z, 1'b0, 1'b1};
				pix_count += 4;
			end
			for (int i = 0; i < pix_count; i++) pending_words.push_back(pix_words[i]);
		end
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
			                                         : int'($urandom_range(0, 10));
			gap = hold_off ? 0 : int'($urandom_range(0, 6));
			if (gap > 0) begin
				tick_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stream checker: items are taken at the rising edge after this sample
	always @(negedge clk) begin : check_stream
		stream_word_t want;
		if (stream_if.valid === 1'b1 && stream_if.ready === 1'b1) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", stream_if.word));
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (stream_if.word !== want.word)
					report_mismatch($sformatf("word %h, want %h",
						stream_if.word, want.word));
				if (stream_if.is_header !== want.is_header)
					report_mismatch($sformatf("is_header %b, want %b on word %h",
						stream_if.is_header, want.is_header, want.word));
				else if (want.is_header)
					headers_checked++;
				if (stream_if.last !== want.last)
					report_mismatch($sformatf("last %b, want %b on word %h",
						stream_if.last, want.last, want.word));
			end
		end
	end

	// Receiver: stall mode is redrawn at random; hold_off overrides
	initial begin : rx_stall
		int       rx_cnt;
		rx_mode_e rx_mode;
		logic     rdy;
		rx_cnt = 0;
		rx_mode = RX_OPEN;
		stream_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cnt++;
			if (rx_cnt % 61 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN:    rdy = 1'b1;
				RX_RANDOM:  rdy = 1'($urandom_range(0, 1));
				RX_HALF:    rdy = rx_cnt[0];
				RX_QUARTER: rdy = (rx_cnt[1:0] == 2'd0);
				default:    rdy = 1'b1;
			endcase
			stream_if.ready <= rdy && !hold_off;
		end
	end

	// Long receiver hold-off during the random part so the block backs up
	initial begin : rx_hold
		wait (rand_started);
		repeat ($urandom_range(10, 40)) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still pending",
				cycle_count, pending_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Main sequence
	initial begin : main_seq
		logic [15:0] wv, hv, bv;
		arst_n = 1'b0;
		write_en = 1'b0;
		reg_index = '0;
		write_data = '0;
		tick_if.valid = 1'b0;
		tick_if.advance = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, idle ticks, shrunk and short blocks,
		// zero and oversize frames, resize past the current position
		dir_rows = '{
			pixel_row(1'b1, 16'h1000, 16'h8001, 16'h4001, 16'h3010),
			tick_row(1'b0),
			pixel_row(1'b0, 16'h0000, 16'h8002, 16'h4001, 16'h0020),
			cfg_row(REG_BLOCK_WORDS, 16'd4),
			pixel_row(1'b0, 16'h0000, 16'h8003, 16'h4001, 16'h0030),
			pixel_row(1'b1, 16'h0004, 16'h8004, 16'h4001, 16'h0040),
			cfg_row(REG_FRAME_WIDTH, 16'd0),
			pixel_row(1'b1, 16'h0004, 16'h8001, 16'h4002, 16'h1010),
			cfg_row(REG_FRAME_HEIGHT, 16'd0),
			cfg_row(REG_BLOCK_WORDS, 16'd2),
			pixel_row(1'b1, 16'h0002, 16'h8001, 16'h4001, 16'h3090),
			tick_row(1'b0),
			tick_row(1'b1),
			cfg_row(REG_FRAME_WIDTH, 16'd8191),
			cfg_row(REG_FRAME_HEIGHT, 16'd8191),
			cfg_row(REG_BLOCK_WORDS, 16'hFFFF),
			tick_row(1'b1), tick_row(1'b1), tick_row(1'b0), tick_row(1'b1),
			cfg_row(REG_FRAME_WIDTH, 16'hE003),
			cfg_row(REG_FRAME_HEIGHT, 16'd2),
			cfg_row(REG_BLOCK_WORDS, 16'd12),
			tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
			tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
			cfg_row(REG_BLOCK_WORDS, 16'd0),
			tick_row(1'b1), tick_row(1'b1)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
			else send_tick(dir_rows[i]);
		end

		// Random settings, mostly small frames so wraps come often;
		// width writes carry junk above bit 12
		rand_started = 1'b1;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0:       wv = 16'd0;
				1:       wv = 16'($urandom_range(8190, 8191));
				2, 3, 4: wv = 16'($urandom_range(1, 4));
				default: wv = 16'($urandom_range(5, 24));
			endcase
			wv = wv | 16'($urandom_range(0, 7) << 13);
			case ($urandom_range(0, 9))
				0:       hv = 16'd0;
				1, 2, 3: hv = 16'($urandom_range(1, 3));
				default: hv = 16'($urandom_range(4, 10));
			endcase
			case ($urandom_range(0, 5))
				0:       bv = 16'($urandom_range(0, 3));
				1:       bv = 16'($urandom);
				default: bv = 16'($urandom_range(4, 40));
			endcase
			write_reg(REG_FRAME_WIDTH, wv);
			write_reg(REG_FRAME_HEIGHT, hv);
			write_reg(REG_BLOCK_WORDS, bv);
			repeat (PHASE_TICKS) send_tick(tick_row($urandom_range(0, 4) != 0));
		end

		// One-pixel frames: every tick wraps the frame and steps the offset
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		write_reg(REG_BLOCK_WORDS, 16'd4);
		repeat (SWEEP_TICKS) send_tick(tick_row(1'b1));

		// Drain and let any stray words show up
		tick_if.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d ticks (%0d pixels) over %0d register writes; checked %0d words",
			ticks_sent, pixels_sent, settings_count, words_checked);
		$display("including %0d block headers; frame offset rolled over %0d time(s)",
			headers_checked, offset_wraps);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
